[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion helpers, synchronous active-high reset.

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/nrdiv_pkg.sv]
`timescale 1ns / 1ps
package nrdiv_pkg;

   localparam logic [15:0] RECIP_XOR = 16'h7FFF;
   localparam logic [15:0] MASK_S8   = 16'hFF00;
   localparam logic [15:0] MASK_S4   = 16'hF000;
   localparam logic [15:0] MASK_S2   = 16'hC000;
   localparam logic [15:0] MASK_S1   = 16'h8000;

   // Sideband that rides along the pipeline with each transaction.
   typedef struct packed {
      logic [15:0] numerator;
      logic [3:0]  shift_applied;   // {s8, s4, s2, s1}
   } nrdiv_side_type;

   // One Newton operand set between stages.
   typedef struct packed {
      logic           vld;
      logic [15:0]    d;
      logic [15:0]    x;
      nrdiv_side_type side;
   } nrdiv_stage_type;

endpackage

[rtl/nrdiv_norm.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nrdiv_norm
   import nrdiv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_vld,
   input  logic [15:0]     in_numerator,
   input  logic [15:0]     in_denominator,
   output nrdiv_stage_type out_stage
);

   logic [15:0] d8, d4, d2, d1, x_raw, x0;
   logic        s8, s4, s2, s1;
   logic        vld_ff, vld_in;
   logic [15:0] d_ff, d_in, x_ff, x_in;
   nrdiv_side_type side_ff, side_in;

   always_comb begin
      s8 = (in_denominator & MASK_S8) == 16'd0;
      d8 = s8 ? {in_denominator[7:0], 8'd0} : in_denominator;
      s4 = (d8 & MASK_S4) == 16'd0;
      d4 = s4 ? {d8[11:0], 4'd0} : d8;
      s2 = (d4 & MASK_S2) == 16'd0;
      d2 = s2 ? {d4[13:0], 2'd0} : d4;
      s1 = (d2 & MASK_S1) == 16'd0;
      d1 = s1 ? {d2[14:0], 1'b0} : d2;
      x_raw = d1 ^ RECIP_XOR;
      x0 = x_raw - {4'd0, x_raw[15:4]};
   end

   assign vld_in = in_vld;
   assign d_in   = d1;
   assign x_in   = x0;
   assign side_in.numerator     = in_numerator;
   assign side_in.shift_applied = {s8, s4, s2, s1};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      d_ff    <= d_in;
      x_ff    <= x_in;
      side_ff <= side_in;
   end

   assign out_stage.vld  = vld_ff;
   assign out_stage.d    = d_ff;
   assign out_stage.x    = x_ff;
   assign out_stage.side = side_ff;

   // Normalized divisor has its top bit set unless it is zero.
   `ASSERT_IMPL(a_norm_msb, clock, reset, vld_ff, d_ff[15] || (d_ff == 16'd0))

endmodule

[rtl/nrdiv_newton.sv]
`timescale 1ns / 1ps
module nrdiv_newton
   import nrdiv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  nrdiv_stage_type in_stage,
   output nrdiv_stage_type out_stage
);

   // Stage A: a = (d * x) >> 16
   logic [31:0]     dx_prod;
   logic [15:0]     a_ff, a_in;
   nrdiv_stage_type sa_ff;

   assign dx_prod = in_stage.d * in_stage.x;
   assign a_in    = dx_prod[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.vld <= 1'b0;
      end else begin
         sa_ff.vld <= in_stage.vld;
      end
      sa_ff.d    <= in_stage.d;
      sa_ff.x    <= in_stage.x;
      sa_ff.side <= in_stage.side;
      a_ff       <= a_in;
   end

   // Stage B: c = bits 30..15 of x * signed(b)
   logic        [15:0] b;
   logic signed [32:0] xb_prod;
   logic        [15:0] c_ff, c_in;
   nrdiv_stage_type    sb_ff;

   assign b       = (a_ff ^ RECIP_XOR) + 16'd1;
   assign xb_prod = $signed({1'b0, sa_ff.x}) * $signed(b);
   assign c_in    = xb_prod[30:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff.vld <= 1'b0;
      end else begin
         sb_ff.vld <= sa_ff.vld;
      end
      sb_ff.d    <= sa_ff.d;
      sb_ff.x    <= sa_ff.x;
      sb_ff.side <= sa_ff.side;
      c_ff       <= c_in;
   end

   // Correction add lands in the consumer's stage.
   assign out_stage.vld  = sb_ff.vld;
   assign out_stage.d    = sb_ff.d;
   assign out_stage.x    = sb_ff.x + c_ff;
   assign out_stage.side = sb_ff.side;

endmodule

[rtl/newton_reciprocal_divider16_unit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Approximate unsigned 16-bit divider, fully pipelined: one transaction may
// be started every clock (busy is always low). rsp_strobe is high with the
// quotient on rsp_quotient after the transaction has passed all stages.
// The receiver cannot stall, so every strobe must be captured in its cycle.
// The stages in order: normalize and estimate, two Newton steps of two
// multiplier stages each, the numerator product, and the output shift.
// A zero divisor is not flagged; it yields the formula-defined value.
module newton_reciprocal_divider16_unit
   import nrdiv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_numerator,
   input  logic [15:0] req_denominator,
   output logic        rsp_strobe,
   output logic [15:0] rsp_quotient
);

   nrdiv_stage_type st_norm, st_n1, st_n2;

   // Pipeline never back-pressures.
   assign busy = 1'b0;

   // Stage 1: shift divisor until bit 15 set, form x0.
   nrdiv_norm u_norm (
      .clock          (clock),
      .reset          (reset),
      .in_vld         (start & ~busy),
      .in_numerator   (req_numerator),
      .in_denominator (req_denominator),
      .out_stage      (st_norm)
   );

   // Stages 2..3 and 4..5: Newton refinements.
   nrdiv_newton u_newton1 (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (st_norm),
      .out_stage (st_n1)
   );

   nrdiv_newton u_newton2 (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (st_n1),
      .out_stage (st_n2)
   );

   // Stage 6: r = n * f, keep which shifts were applied.
   logic        r_vld_ff;
   logic [31:0] r_ff, r_in;
   logic [3:0]  r_shift_ff;

   assign r_in = st_n2.side.numerator * st_n2.x;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else begin
         r_vld_ff <= st_n2.vld;
      end
      r_ff       <= r_in;
      r_shift_ff <= st_n2.side.shift_applied;
   end

   // Stage 7: undo the shifts NOT applied. {~s8,~s4,~s2,~s1} is the binary
   // right-shift amount (8+4+2+1 weights).
   logic [3:0]  rsh_amt;
   logic [31:0] r_shifted;
   logic        rsp_strobe_ff;
   logic [15:0] rsp_quotient_ff, rsp_quotient_in;

   assign rsh_amt         = ~r_shift_ff;
   assign r_shifted       = r_ff >> rsh_amt;
   assign rsp_quotient_in = r_shifted[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= r_vld_ff;
      end
      rsp_quotient_ff <= rsp_quotient_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_quotient = rsp_quotient_ff;

   // Every started transaction comes out with rsp_strobe.
   `ASSERT_IMPL(a_start_to_strobe, clock, reset, start && !busy, ##7 rsp_strobe)
   // No strobe without a start at the matching earlier edge.
   `ASSERT_IMPL(a_strobe_has_start, clock, reset, rsp_strobe, $past(start, 7))
   // Product stage valid follows second Newton step valid.
   `ASSERT_NEXT(a_prod_follows, clock, reset, st_n2.vld, r_vld_ff)

endmodule
